[rtl/gmdfs_pkg.sv]
// ----------------------------------------------------------------------------
// gmdfs_pkg
// Shared types and constants for the grid maze depth-first path finder.
// ----------------------------------------------------------------------------
package gmdfs_pkg;

  localparam int unsigned GridSideDefault   = 8;
  localparam int unsigned StackDepthDefault = 64;
  localparam int unsigned CellW             = 6;
  localparam int unsigned CoordW            = 3;
  localparam int unsigned CfgIdxW           = 2;
  localparam int unsigned CfgDataW          = 64;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgWallMap = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRows    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCols    = 2'd2;

  // Search directions in the order they are tried.
  localparam logic [1:0] DirLeft  = 2'd0;
  localparam logic [1:0] DirUp    = 2'd1;
  localparam logic [1:0] DirRight = 2'd2;
  localparam logic [1:0] DirDown  = 2'd3;

  typedef struct packed {
    logic [CoordW-1:0] start_row;
    logic [CoordW-1:0] start_col;
    logic [CoordW-1:0] goal_row;
    logic [CoordW-1:0] goal_col;
  } req_t;

  typedef struct packed {
    logic [CoordW-1:0] cell_row;
    logic [CoordW-1:0] cell_col;
    logic              found;
    logic              last;
  } res_t;

  // A classified request as handed from the front part to the search engine.
  typedef struct packed {
    logic              reject;
    logic [CellW-1:0]  start;
    logic [CellW-1:0]  goal;
  } job_t;

  // Clamp a 4-bit size register to 1..side.
  function automatic logic [3:0] clamp_size(input logic [3:0] v, input logic [3:0] side);
    logic [3:0] r;
    r = v;
    if (v == 4'd0) r = 4'd1;
    if (v > side) r = side;
    return r;
  endfunction

endpackage

[rtl/gmdfs_front.sv]
// ----------------------------------------------------------------------------
// gmdfs_front
// Accepts solve requests, checks bounds and the start wall, and queues jobs.
// ----------------------------------------------------------------------------
module gmdfs_front #(
  parameter int unsigned GridSide = gmdfs_pkg::GridSideDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid,
  output logic              in_stall,
  input  gmdfs_pkg::req_t   in_data,
  input  logic [63:0]       wall_i,
  input  logic [3:0]        rows_i,
  input  logic [3:0]        cols_i,
  output logic              job_valid_o,
  input  logic              job_pop_i,
  output gmdfs_pkg::job_t   job_o
);
  import gmdfs_pkg::*;

  localparam logic [3:0] SideL = 4'(GridSide);

  // Two-entry job queue.
  job_t       q_mem [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  job_t       job_d;
  logic [3:0] rows, cols;
  logic [CellW-1:0] s_idx;
  logic       push;

  // Classify the incoming request.
  always_comb begin
    rows  = clamp_size(rows_i, SideL);
    cols  = clamp_size(cols_i, SideL);
    s_idx = CellW'(in_data.start_row * GridSide + in_data.start_col);
    job_d.start = s_idx;
    job_d.goal  = CellW'(in_data.goal_row * GridSide + in_data.goal_col);
    job_d.reject = ({1'b0, in_data.start_row} >= rows) || ({1'b0, in_data.start_col} >= cols)
                || ({1'b0, in_data.goal_row} >= rows) || ({1'b0, in_data.goal_col} >= cols)
                || wall_i[s_idx];
  end

  assign in_stall    = (cnt_q == 2'd2);
  assign push        = in_valid && !in_stall;
  assign job_valid_o = (cnt_q != 2'd0);
  assign job_o       = q_mem[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (push) q_mem[wr_ptr_q] <= job_d;
  end

  // Queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (job_pop_i) rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(job_pop_i);
    end
  end

endmodule

[rtl/gmdfs_engine.sv]
// ----------------------------------------------------------------------------
// gmdfs_engine
// Stack-based depth-first search, then path readout from the stack top.
// ----------------------------------------------------------------------------
module gmdfs_engine #(
  parameter int unsigned GridSide   = gmdfs_pkg::GridSideDefault,
  parameter int unsigned StackDepth = gmdfs_pkg::StackDepthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  output logic              job_pop_o,
  input  gmdfs_pkg::job_t   job_i,
  input  logic [63:0]       wall_i,
  input  logic [3:0]        rows_i,
  input  logic [3:0]        cols_i,
  output logic              out_valid,
  input  logic              out_stall,
  output gmdfs_pkg::res_t   out_data
);
  import gmdfs_pkg::*;

  localparam int unsigned SpW   = $clog2(StackDepth);
  localparam int unsigned LvlW  = SpW + 1;
  localparam logic [3:0]  SideL = 4'(GridSide);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRead = 3'd1;
  localparam logic [2:0] StStep = 3'd2;
  localparam logic [2:0] StEmit = 3'd3;
  localparam logic [2:0] StNone = 3'd4;

  logic [2:0]      state_q, state_d;
  logic [7:0]      stack_mem [StackDepth];
  logic [7:0]      rd_q;
  logic [LvlW-1:0] lvl_q, lvl_d;
  logic [63:0]     vis_q, vis_d;
  logic [CellW-1:0] goal_q, goal_d;
  logic            ov_q, ov_d;
  res_t            od_q, od_d;
  logic            we1, we2;
  logic [SpW-1:0]  wa1, wa2, ra;
  logic [7:0]      wd1, wd2;

  logic [3:0]      rows, cols;
  logic [CellW-1:0] cur_cell, nb;
  logic [1:0]      dir;
  logic [2:0]      r, c, nr, nc;
  logic            ok;
  logic            slot_free;

  assign rows = clamp_size(rows_i, SideL);
  assign cols = clamp_size(cols_i, SideL);
  assign cur_cell = rd_q[CellW-1:0];
  assign dir  = rd_q[7:6];
  assign r    = 3'(cur_cell / GridSide);
  assign c    = 3'(cur_cell % GridSide);
  assign slot_free = !ov_q || !out_stall;

  // Neighbour selection and blocking test.
  always_comb begin
    nr = r;
    nc = c;
    ok = 1'b0;
    unique case (dir)
      DirLeft:  if (c != 3'd0) begin nc = c - 3'd1; ok = 1'b1; end
      DirUp:    if (r != 3'd0) begin nr = r - 3'd1; ok = 1'b1; end
      DirRight: if ({1'b0, c} + 4'd1 < cols) begin nc = c + 3'd1; ok = 1'b1; end
      DirDown:  if ({1'b0, r} + 4'd1 < rows) begin nr = r + 3'd1; ok = 1'b1; end
      default:  ok = 1'b0;
    endcase
    nb = CellW'(nr * GridSide + nc);
    if (wall_i[nb] || vis_q[nb] || (lvl_q >= LvlW'(StackDepth))) ok = 1'b0;
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    lvl_d   = lvl_q;
    vis_d   = vis_q;
    goal_d  = goal_q;
    ov_d    = ov_q && out_stall;
    od_d    = od_q;
    job_pop_o = 1'b0;
    we1 = 1'b0; wa1 = '0; wd1 = '0;
    we2 = 1'b0; wa2 = '0; wd2 = '0;
    ra  = SpW'(lvl_q - LvlW'(1));
    unique case (state_q)
      StIdle: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          goal_d = job_i.goal;
          if (job_i.reject) begin
            state_d = StNone;
          end else begin
            vis_d = 64'd1 << job_i.start;
            lvl_d = LvlW'(1);
            we1 = 1'b1; wa1 = '0; wd1 = {DirLeft, job_i.start};
            state_d = StRead;
          end
        end
      end
      StRead: begin
        state_d = StStep;
      end
      StStep: begin
        if (cur_cell == goal_q) begin
          state_d = StEmit;
        end else begin
          if (dir != DirDown) begin
            we1 = 1'b1; wa1 = ra; wd1 = {dir + 2'd1, cur_cell};
          end
          if (ok) begin
            vis_d = vis_q | (64'd1 << nb);
            we2 = 1'b1; wa2 = SpW'(lvl_q); wd2 = {DirLeft, nb};
            lvl_d = lvl_q + LvlW'(1);
            state_d = StRead;
          end else if (dir == DirDown) begin
            lvl_d = lvl_q - LvlW'(1);
            state_d = (lvl_q == LvlW'(1)) ? StNone : StRead;
          end else begin
            state_d = StRead;
          end
        end
      end
      StEmit: begin
        if (slot_free) begin
          ov_d = 1'b1;
          od_d.cell_row = r;
          od_d.cell_col = c;
          od_d.found    = 1'b1;
          od_d.last     = (lvl_q == LvlW'(1));
          lvl_d = lvl_q - LvlW'(1);
          state_d = (lvl_q == LvlW'(1)) ? StIdle : StRead;
          ra = SpW'(lvl_q - LvlW'(2));
        end
      end
      StNone: begin
        if (slot_free) begin
          ov_d = 1'b1;
          od_d = '{cell_row: '0, cell_col: '0, found: 1'b0, last: 1'b1};
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Emission continuation: after an emit the sequencer names the read state next.
  // The read state is shared, so a flag marks emit continuation and sends it to emit.
  logic emit_q, emit_d;
  always_comb begin
    emit_d = emit_q;
    if (state_q == StStep && cur_cell == goal_q) emit_d = 1'b1;
    if (state_q == StIdle) emit_d = 1'b0;
  end

  // Stack memory: writes and one registered read.
  always_ff @(posedge clk_i) begin
    if (we1) stack_mem[wa1] <= wd1;
    if (we2) stack_mem[wa2] <= wd2;
    rd_q <= stack_mem[(state_q == StEmit) ? ra : SpW'(lvl_d - LvlW'(1))];
  end

  always_ff @(posedge clk_i) begin
    od_q <= od_d;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      lvl_q   <= '0;
      vis_q   <= '0;
      goal_q  <= '0;
      ov_q    <= 1'b0;
      emit_q  <= 1'b0;
    end else begin
      state_q <= (state_d == StRead && emit_d) ? StEmit : state_d;
      lvl_q   <= lvl_d;
      vis_q   <= vis_d;
      goal_q  <= goal_d;
      ov_q    <= ov_d;
      emit_q  <= emit_d;
    end
  end

  assign out_valid = ov_q;
  assign out_data  = od_q;

endmodule

[rtl/grid_maze_dfs_path.sv]
// ----------------------------------------------------------------------------
// grid_maze_dfs_path
// Depth-first path finder on a configurable wall grid, path goal to start.
// ----------------------------------------------------------------------------
//   channel | direction | handshake       | beat
//   in      | input     | in_valid/stall  | start and goal cells
//   out     | output    | out_valid/stall | one path cell or no-path mark
//   cfg     | input     | cfg_valid/ready | register index and data
//
// The front checks a request in the cycle it is accepted and queues it (two
// entries). A search step is a registered stack read and one direction tried;
// a full 8x8 grid needs at most about 260 steps. The readout then gives one
// cell per cycle while the output does not stall. Reset is asynchronous,
// active low, and restores the register defaults. Output stalls hold only
// the readout and the no-path beat; the input stalls while two jobs wait.
module grid_maze_dfs_path #(
  parameter int unsigned GridSide   = gmdfs_pkg::GridSideDefault,
  parameter int unsigned StackDepth = gmdfs_pkg::StackDepthDefault
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  gmdfs_pkg::req_t                     in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output gmdfs_pkg::res_t                     out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [gmdfs_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [gmdfs_pkg::CfgDataW-1:0]      cfg_data
);
  import gmdfs_pkg::*;

  logic [63:0] wall_q;
  logic [3:0]  rows_q, cols_q;
  logic        job_valid, job_pop;
  job_t        job;

  assign cfg_ready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wall_q <= '0;
      rows_q <= 4'd5;
      cols_q <= 4'd5;
    end else if (cfg_valid) begin
      case (cfg_index)
        CfgWallMap: wall_q <= cfg_data;
        CfgRows:    rows_q <= cfg_data[3:0];
        CfgCols:    cols_q <= cfg_data[3:0];
        default:    ;
      endcase
    end
  end

  gmdfs_front #(.GridSide(GridSide)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_stall, .in_data,
    .wall_i(wall_q), .rows_i(rows_q), .cols_i(cols_q),
    .job_valid_o(job_valid), .job_pop_i(job_pop), .job_o(job)
  );

  gmdfs_engine #(.GridSide(GridSide), .StackDepth(StackDepth)) u_engine (
    .clk_i, .rst_ni, .job_valid_i(job_valid), .job_pop_o(job_pop), .job_i(job),
    .wall_i(wall_q), .rows_i(rows_q), .cols_i(cols_q),
    .out_valid, .out_stall, .out_data
  );

  // A no-path beat is always the final one.
  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.found |-> out_data.last) else $error("no-path beat not last");

  // Jobs are only taken when queued.
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_pop |-> job_valid) else $error("pop from empty queue");

endmodule
